// ----- hdl/mws2d_pkg.sv -----
package mws2d_pkg;
   localparam int N_MAX = 128;
   localparam int IDX_W = 8;
   localparam int ADDR_W = 14;
   localparam int SUM_W = 32;
   localparam logic [SUM_W-1:0] NO_WINDOW = 32'h88CA_6C00;
   localparam logic [1:0] CSR_SIZE = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_WIDTH = 2'd2;

   typedef struct packed {
      logic load;
      logic restart;
      logic search_start;
   } cmd_type;

   typedef struct packed {
      logic last_cell;
      logic load_done;
      logic search_done;
   } status_type;
endpackage

// ----- hdl/max_window_sum_2d.sv -----
// Channel | Direction | Signals
// req     | in        | req_valid, req_ready, req_cell_value[15:0]
// rsp     | out       | rsp_valid, rsp_ready, rsp_best_exact_window, rsp_best_bounded_height
// csr     | in        | csr_valid, csr_ready, csr_index[1:0], csr_data[7:0]
// For a cell, the accept cycle reads the table and the next one writes it.
// After the last cell the search visits each window position with 4 table reads,
// over all tops, heights up to window_height and right columns.
// Cell and register ports stall while a cell loads, during the search and until the
// result item is taken; a register write is taken ahead of a waiting cell.
// Reset is synchronous; the table is not cleared, every read entry is written first.
module max_window_sum_2d (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_best_exact_window,
   output logic signed [31:0] rsp_best_bounded_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);
   logic [7:0] size_ff, height_ff, width_ff;
   logic signed [15:0] cell_ff;
   logic size_write;
   mws2d_pkg::cmd_type cmd;
   mws2d_pkg::status_type status;
   logic [31:0] be, bb;

   assign size_write = csr_valid && csr_ready && (csr_index == mws2d_pkg::CSR_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 8'd128; height_ff <= 8'd1; width_ff <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mws2d_pkg::CSR_SIZE: size_ff <= csr_data;
            mws2d_pkg::CSR_HEIGHT: height_ff <= csr_data;
            mws2d_pkg::CSR_WIDTH: width_ff <= csr_data;
            default: ;
         endcase
      end
      if (req_valid && req_ready) cell_ff <= req_cell_value;
   end

   mws2d_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .csr_valid, .csr_ready, .size_write, .cmd, .status
   );

   mws2d_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .cell_value(cell_ff), .size_reg(size_ff), .height_reg(height_ff),
      .width_reg(width_ff), .best_exact(be), .best_bounded(bb)
   );

   assign rsp_best_exact_window = be;
   assign rsp_best_bounded_height = bb;
endmodule

// ----- hdl/mws2d_datapath.sv -----
module mws2d_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  mws2d_pkg::cmd_type           cmd,
   output mws2d_pkg::status_type        status,
   input  logic signed [15:0]           cell_value,
   input  logic [7:0]                   size_reg,
   input  logic [7:0]                   height_reg,
   input  logic [7:0]                   width_reg,
   output logic [31:0]                  best_exact,
   output logic [31:0]                  best_bounded
);
   // Load: each cell takes one read of S(r-1,c) then one write.
   // Search: for each (top, height, right) four reads of the table, one per cycle.
   logic [31:0] mem [0:mws2d_pkg::N_MAX*mws2d_pkg::N_MAX-1];
   logic [mws2d_pkg::ADDR_W-1:0] raddr;
   logic [31:0] rdata_ff;
   logic        we;
   logic [mws2d_pkg::ADDR_W-1:0] waddr;
   logic [31:0] wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   logic [7:0] n;
   always_comb begin
      n = size_reg;
      if (n == 8'd0) n = 8'd1;
      if (n > 8'(mws2d_pkg::N_MAX)) n = 8'(mws2d_pkg::N_MAX);
   end

   // Load engine
   logic [7:0] row_ff, row_in, col_ff, col_in;
   logic [31:0] run_ff, run_in;
   logic [1:0] lph_ff, lph_in;
   logic [31:0] cell_ext;
   logic [31:0] run_new;
   assign cell_ext = {{16{cell_value[15]}}, cell_value};
   assign run_new = ((col_ff == 8'd0) ? 32'd0 : run_ff) + cell_ext;

   // Search engine
   logic [7:0] top_ff, top_in, bot_ff, bot_in, rc_ff, rc_in;
   logic [2:0] sph_ff, sph_in;
   logic       srun_ff, srun_in;
   logic [31:0] acc_ff, acc_in, bexact_ff, bexact_in, bbnd_ff, bbnd_in;
   logic [7:0] p_eff;
   logic       valid_ex, valid_bd;
   logic [7:0] tr, tc;
   logic       tzero_ff, tzero_in;
   logic [31:0] tval;

   assign valid_bd = (height_reg != 8'd0) && (width_reg != 8'd0) && (width_reg <= n);
   assign valid_ex = valid_bd && (height_reg <= n);
   assign p_eff = (height_reg > n) ? n : height_reg;
   assign tval = tzero_ff ? 32'd0 : rdata_ff;

   // Table read address for search phase
   always_comb begin
      tr = bot_ff;
      tc = rc_ff;
      case (sph_ff)
         3'd0: begin tr = bot_ff; tc = rc_ff; end
         3'd1: begin tr = top_ff; tc = rc_ff; end
         3'd2: begin tr = bot_ff; tc = rc_ff - width_reg; end
         3'd3: begin tr = top_ff; tc = rc_ff - width_reg; end
         default: begin tr = bot_ff; tc = rc_ff; end
      endcase
   end

   logic [7:0] bot_limit;
   logic [8:0] top_plus_p;
   assign top_plus_p = {1'b0, top_ff} + {1'b0, p_eff};
   assign bot_limit = (top_plus_p > {1'b0, n}) ? n : top_plus_p[7:0];

   always_comb begin
      row_in = row_ff; col_in = col_ff; run_in = run_ff; lph_in = lph_ff;
      top_in = top_ff; bot_in = bot_ff; rc_in = rc_ff; sph_in = sph_ff;
      srun_in = srun_ff; acc_in = acc_ff; bexact_in = bexact_ff; bbnd_in = bbnd_ff;
      tzero_in = tzero_ff;
      we = 1'b0;
      waddr = {row_ff[6:0], col_ff[6:0]};
      wdata = rdata_ff + run_new;
      raddr = {row_ff[6:0] - 7'd1, col_ff[6:0]};
      status.last_cell = (row_ff + 8'd1 >= n) && (col_ff + 8'd1 >= n);
      status.load_done = 1'b0;
      // The search engine reports done whenever it is not walking the table.
      status.search_done = !srun_ff;
      if (cmd.restart || row_ff >= n || col_ff >= n) begin
         row_in = 8'd0; col_in = 8'd0; run_in = 32'd0; lph_in = 2'd0;
      end
      if (cmd.load) begin
         if (lph_ff == 2'd0) begin
            lph_in = 2'd1;
         end else begin
            // row 0 has no row above: prefix is just the running row sum
            we = 1'b1;
            wdata = ((row_ff == 8'd0) ? 32'd0 : rdata_ff) + run_new;
            lph_in = 2'd0;
            run_in = run_new;
            status.load_done = 1'b1;
            if (col_ff + 8'd1 < n) begin
               col_in = col_ff + 8'd1;
            end else begin
               col_in = 8'd0; run_in = 32'd0;
               row_in = (row_ff + 8'd1 < n) ? row_ff + 8'd1 : 8'd0;
            end
         end
      end
      if (cmd.search_start) begin
         bexact_in = mws2d_pkg::NO_WINDOW;
         bbnd_in = mws2d_pkg::NO_WINDOW;
         top_in = 8'd0; bot_in = 8'd1; rc_in = width_reg; sph_in = 3'd0;
         srun_in = valid_bd;
      end else if (srun_ff) begin
         raddr = {tr[6:0] - 7'd1, tc[6:0] - 7'd1};
         tzero_in = (tr == 8'd0) || (tc == 8'd0);
         // sph 1..4 consume the value read in the previous cycle
         case (sph_ff)
            3'd0: sph_in = 3'd1;
            3'd1: begin acc_in = tval; sph_in = 3'd2; end
            3'd2: begin acc_in = acc_ff - tval; sph_in = 3'd3; end
            3'd3: begin acc_in = acc_ff - tval; sph_in = 3'd4; end
            3'd4: begin
               acc_in = acc_ff + tval;
               sph_in = 3'd5;
            end
            3'd5: begin
               if ($signed(acc_ff) > $signed(bbnd_ff)) bbnd_in = acc_ff;
               if (valid_ex && (bot_ff - top_ff == height_reg) &&
                   $signed(acc_ff) > $signed(bexact_ff)) bexact_in = acc_ff;
               sph_in = 3'd0;
               if (rc_ff < n) begin
                  rc_in = rc_ff + 8'd1;
               end else begin
                  rc_in = width_reg;
                  if (bot_ff < bot_limit) begin
                     bot_in = bot_ff + 8'd1;
                  end else if (top_ff + 8'd1 < n) begin
                     top_in = top_ff + 8'd1; bot_in = top_ff + 8'd2;
                  end else begin
                     srun_in = 1'b0;
                  end
               end
            end
            default: sph_in = 3'd0;
         endcase
      end
      if (cmd.search_start) begin
         raddr = {row_ff[6:0], col_ff[6:0]};
      end
      // phases 0..3 issue reads; phase 4's read is unused
      if (srun_ff && sph_ff == 3'd4) begin
         raddr = {row_ff[6:0], col_ff[6:0]};
      end
   end

   // Phase sequencing: read issued in phase k is consumed in phase k+1.
   // Phases 0,1,2,3 issue reads for terms 1..4; the address select uses sph_ff
   // so term order is bot/right, top/right, bot/left, top/left.

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= 8'd0; col_ff <= 8'd0; run_ff <= 32'd0; lph_ff <= 2'd0;
         srun_ff <= 1'b0; sph_ff <= 3'd0;
      end else begin
         row_ff <= row_in; col_ff <= col_in; run_ff <= run_in; lph_ff <= lph_in;
         srun_ff <= srun_in; sph_ff <= sph_in;
      end
      top_ff <= top_in; bot_ff <= bot_in; rc_ff <= rc_in;
      acc_ff <= acc_in; tzero_ff <= tzero_in;
      bexact_ff <= bexact_in; bbnd_ff <= bbnd_in;
   end

   assign best_exact = bexact_ff;
   assign best_bounded = bbnd_ff;
endmodule

// ----- hdl/mws2d_ctrl.sv -----
module mws2d_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   size_write,
   output mws2d_pkg::cmd_type     cmd,
   input  mws2d_pkg::status_type  status
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_RESULT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      cmd.restart = size_write;
      // A register write goes ahead of a waiting cell so the two never share an edge.
      csr_ready = (state_ff == S_IDLE);
      req_ready = (state_ff == S_IDLE) && !csr_valid;
      rsp_valid = (state_ff == S_RESULT);
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            last_in = status.last_cell;
            state_in = S_LOAD;
            cmd.load = 1'b1;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            if (status.load_done) begin
               if (last_ff) begin
                  cmd.search_start = 1'b1;
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SEARCH: if (status.search_done) state_in = S_RESULT;
         S_RESULT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end
endmodule
